FILE: design/pmbh_pkg.sv
// Package for the Prim spanning-tree block: widths, modes, colors,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
`default_nettype none
package pmbh_pkg;
  localparam int MaxVertices = 32;
  localparam int VtxBits     = 5;
  localparam int CntBits     = 6;
  localparam int WeightBits  = 16;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    COL_UNVISITED = 2'd0,
    COL_QUEUED    = 2'd1,
    COL_DONE      = 2'd2
  } colour_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_INIT,
    ST_POP,
    ST_SIFT_DOWN,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN,
    ST_FIND,
    ST_SIFT_UP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic           load;        // capture input beat
    logic           add_a;       // append b to list of a, write weight
    logic           add_b;       // append a to list of b, write weight
    logic           clear;       // zero neighbour counts
    logic           init;        // reset run state, push source
    logic           pop;         // extract root
    logic           wt_rd;       // issue weight read for the fetched neighbour
    logic           sd_step;     // one sift-down compare/swap
    logic           scan_rd;     // issue neighbour read
    logic           scan;        // process one neighbour
    logic           find_step;   // search heap for vertex
    logic           su_step;     // one sift-up compare/swap
    logic           emit_next;   // advance report index
  } cmd_t;

  typedef struct packed {
    logic add_ok;        // edge endpoints in range
    logic run_ok;        // source in range
    logic heap_empty;
    logic pop_skip;      // popped vertex out of range
    logic sd_more;       // sift-down continues
    logic scan_more;     // neighbours left
    logic scan_push;     // neighbour pushed, start sift-up
    logic scan_lower;    // key lowered, start find
    logic find_hit;
    logic find_end;
    logic su_more;
    logic emit_last;
  } sts_t;
endpackage
`default_nettype wire

FILE: design/pmbh_datapath.sv
// Datapath: edge memories, per-vertex state, heap store and report logic.
// Depends on pmbh_pkg; driven by pmbh_ctrl through cmd_t / sts_t.
`default_nettype none
module pmbh_datapath
  import pmbh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic                  cfg_we,
  input  wire logic [CntBits-1:0]    cfg_wdata,
  input  wire logic [VtxBits-1:0]    vertex_a,
  input  wire logic [VtxBits-1:0]    vertex_b,
  input  wire logic [WeightBits-1:0] weight,
  output logic [VtxBits-1:0]         vertex,
  output logic [VtxBits-1:0]         parent,
  output logic                       has_parent,
  output logic                       last
);
  logic [CntBits-1:0]    num_vertices;
  logic [CntBits-1:0]    n_used;
  logic [VtxBits-1:0]    a_reg, b_reg;
  logic [WeightBits-1:0] w_reg;

  // edge memories
  logic [WeightBits-1:0] wmem [MaxVertices*MaxVertices];
  logic [VtxBits-1:0]    lmem [MaxVertices*MaxVertices];
  logic [WeightBits-1:0] wmem_q;
  logic [VtxBits-1:0]    lmem_q;

  logic [CntBits-1:0]    ncount [MaxVertices];
  colour_t               colour [MaxVertices];
  logic [VtxBits-1:0]    par    [MaxVertices];
  logic                  pvalid [MaxVertices];
  logic [WeightBits-1:0] key    [MaxVertices];
  logic [WeightBits-1:0] hkey   [MaxVertices];
  logic [VtxBits-1:0]    hvtx   [MaxVertices];
  logic [CntBits-1:0]    hcount;

  logic [VtxBits-1:0]    u_reg;
  logic [CntBits-1:0]    k_reg;
  logic [VtxBits-1:0]    v_reg;
  logic [CntBits-1:0]    i_reg;   // heap cursor for sift/find
  logic [VtxBits-1:0]    out_idx;

  always_ff @(posedge clk) begin
    if (rst) num_vertices <= CntBits'(MaxVertices);
    else if (cfg_we) num_vertices <= cfg_wdata;
  end
  assign n_used = (num_vertices > CntBits'(MaxVertices)) ? CntBits'(MaxVertices)
                                                         : num_vertices;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg <= vertex_a; b_reg <= vertex_b; w_reg <= weight;
    end
  end

  // add-edge address and data
  logic [VtxBits-1:0] add_src, add_dst;
  logic [CntBits-1:0] add_cnt;
  assign add_src = cmd.add_a ? a_reg : b_reg;
  assign add_dst = cmd.add_a ? b_reg : a_reg;
  assign add_cnt = ncount[add_src];

  // memory ports: one write each, registered reads; neighbour first, then its weight
  always_ff @(posedge clk) begin
    if (cmd.add_a || cmd.add_b) begin
      wmem[{add_src, add_dst}] <= w_reg;
      if (add_cnt < CntBits'(MaxVertices))
        lmem[{add_src, add_cnt[VtxBits-1:0]}] <= add_dst;
    end
    if (cmd.scan_rd) lmem_q <= lmem[{u_reg, k_reg[VtxBits-1:0]}];
    if (cmd.wt_rd) wmem_q <= wmem[{u_reg, lmem_q}];
  end

  // heap helpers
  logic [CntBits-1:0] par_idx, l_idx, r_idx, m_idx;
  logic [CntBits-1:0] hlast;
  assign par_idx = (i_reg - CntBits'(1)) >> 1;
  assign l_idx   = {i_reg[CntBits-2:0], 1'b1};
  assign r_idx   = l_idx + CntBits'(1);
  assign hlast   = hcount - CntBits'(1);

  logic r_in, l_in, sd_swap_r, sd_swap_l;
  assign r_in = (r_idx < hcount) && (i_reg < CntBits'(MaxVertices/2));
  assign l_in = (l_idx < hcount) && (i_reg < CntBits'(MaxVertices/2));
  assign m_idx = (r_in && hkey[l_idx[VtxBits-1:0]] > hkey[r_idx[VtxBits-1:0]]) ? r_idx : l_idx;
  assign sd_swap_r = r_in && (hkey[i_reg[VtxBits-1:0]] > hkey[m_idx[VtxBits-1:0]]);
  assign sd_swap_l = !r_in && l_in &&
                     (hkey[l_idx[VtxBits-1:0]] < hkey[i_reg[VtxBits-1:0]]);

  logic su_swap;
  assign su_swap = (i_reg != '0) &&
                   (hkey[i_reg[VtxBits-1:0]] < hkey[par_idx[VtxBits-1:0]]);

  logic v_in;
  logic push_ok;
  assign v_in    = {1'b0, lmem_q} < n_used;
  assign push_ok = v_in && colour[lmem_q] == COL_UNVISITED;

  logic [VtxBits-1:0] sw_a, sw_b;
  logic               do_swap;
  always_comb begin
    do_swap = 1'b0; sw_a = i_reg[VtxBits-1:0]; sw_b = i_reg[VtxBits-1:0];
    if (cmd.sd_step && (sd_swap_r || sd_swap_l)) begin
      do_swap = 1'b1; sw_b = sd_swap_r ? m_idx[VtxBits-1:0] : l_idx[VtxBits-1:0];
    end else if (cmd.su_step && su_swap) begin
      do_swap = 1'b1; sw_b = par_idx[VtxBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcount <= '0;
      for (int j = 0; j < MaxVertices; j++) begin
        ncount[j] <= '0; colour[j] <= COL_UNVISITED; pvalid[j] <= 1'b0;
      end
    end else begin
      if (cmd.clear)
        for (int j = 0; j < MaxVertices; j++) ncount[j] <= '0;
      if ((cmd.add_a || cmd.add_b) && add_cnt < CntBits'(MaxVertices))
        ncount[add_src] <= add_cnt + CntBits'(1);
      if (cmd.init) begin
        for (int j = 0; j < MaxVertices; j++)
          if (VtxBits'(j) == a_reg) begin
            colour[j] <= COL_QUEUED; par[j] <= a_reg;
            pvalid[j] <= 1'b1; key[j] <= '0;
          end else if (CntBits'(j) < n_used) begin
            colour[j] <= COL_UNVISITED; pvalid[j] <= 1'b0;
            par[j] <= '0; key[j] <= '0;
          end
        hkey[0] <= '0; hvtx[0] <= a_reg; hcount <= CntBits'(1);
      end
      if (cmd.pop) begin
        u_reg <= hvtx[0];
        hkey[0] <= hkey[hlast[VtxBits-1:0]];
        hvtx[0] <= hvtx[hlast[VtxBits-1:0]];
        hcount <= hlast;
        i_reg <= '0;
        k_reg <= '0;
        if ({1'b0, hvtx[0]} < n_used) colour[hvtx[0]] <= COL_DONE;
      end
      if (do_swap) begin
        hkey[sw_a] <= hkey[sw_b]; hvtx[sw_a] <= hvtx[sw_b];
        hkey[sw_b] <= hkey[sw_a]; hvtx[sw_b] <= hvtx[sw_a];
      end
      if (cmd.sd_step && sd_swap_r) i_reg <= m_idx;
      if (cmd.su_step && su_swap) i_reg <= par_idx;
      if (cmd.scan) begin
        k_reg <= k_reg + CntBits'(1);
        v_reg <= lmem_q;
        if (push_ok) begin
          colour[lmem_q] <= COL_QUEUED; par[lmem_q] <= u_reg;
          pvalid[lmem_q] <= 1'b1; key[lmem_q] <= wmem_q;
          if (hcount < CntBits'(MaxVertices)) begin
            hkey[hcount[VtxBits-1:0]] <= wmem_q;
            hvtx[hcount[VtxBits-1:0]] <= lmem_q;
            hcount <= hcount + CntBits'(1);
          end
          i_reg <= hcount;
        end else if (v_in && colour[lmem_q] == COL_QUEUED && key[lmem_q] > wmem_q) begin
          key[lmem_q] <= wmem_q; par[lmem_q] <= u_reg;
          i_reg <= '0;
        end
      end
      if (cmd.find_step) begin
        if (hvtx[i_reg[VtxBits-1:0]] == v_reg) hkey[i_reg[VtxBits-1:0]] <= key[v_reg];
        else i_reg <= i_reg + CntBits'(1);
      end
      if (cmd.init) out_idx <= '0;
      else if (cmd.emit_next) out_idx <= out_idx + VtxBits'(1);
    end
  end

  logic lower_ok;
  assign lower_ok = v_in && colour[lmem_q] == COL_QUEUED && key[lmem_q] > wmem_q;

  always_comb begin
    sts.add_ok     = ({1'b0, a_reg} < n_used) && ({1'b0, b_reg} < n_used);
    sts.run_ok     = {1'b0, a_reg} < n_used;
    sts.heap_empty = hcount == '0;
    sts.pop_skip   = {1'b0, u_reg} >= n_used;
    sts.sd_more    = sd_swap_r;
    sts.scan_more  = (k_reg < ncount[u_reg]) && (k_reg < CntBits'(MaxVertices));
    sts.scan_push  = push_ok && hcount < CntBits'(MaxVertices);
    sts.scan_lower = lower_ok;
    sts.find_hit   = hvtx[i_reg[VtxBits-1:0]] == v_reg;
    sts.find_end   = i_reg >= hcount;
    sts.su_more    = su_swap;
    sts.emit_last  = ({1'b0, out_idx} + CntBits'(1)) == n_used;
  end

  assign vertex     = out_idx;
  assign has_parent = pvalid[out_idx];
  assign parent     = pvalid[out_idx] ? par[out_idx] : '0;
  assign last       = sts.emit_last;
endmodule
`default_nettype wire

FILE: design/pmbh_ctrl.sv
// Controller state machine sequencing edge loads and the Prim run.
// Depends on pmbh_pkg; commands pmbh_datapath through cmd_t / sts_t.
`default_nettype none
module pmbh_ctrl
  import pmbh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode_t'(mode))
            MODE_ADD:   state_next = ST_ADD_A;
            MODE_RUN:   state_next = ST_INIT;
            MODE_CLEAR: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_A:        state_next = sts.add_ok ? ST_ADD_B : ST_IDLE;
      ST_ADD_B:        state_next = ST_IDLE;
      ST_INIT:         state_next = sts.run_ok ? ST_POP : ST_IDLE;
      ST_POP:          state_next = ST_SIFT_DOWN;
      ST_SIFT_DOWN:    if (!sts.sd_more) state_next = ST_SCAN_RD;
      ST_SCAN_RD: begin
        if (sts.pop_skip || !sts.scan_more)
          state_next = sts.heap_empty ? ST_EMIT : ST_POP;
        else state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_push) state_next = ST_SIFT_UP;
        else if (sts.scan_lower) state_next = ST_FIND;
        else state_next = ST_SCAN_RD;
      end
      ST_FIND: begin
        if (sts.find_end) state_next = ST_SCAN_RD;
        else if (sts.find_hit) state_next = ST_SIFT_UP;
      end
      ST_SIFT_UP:      if (!sts.su_more) state_next = ST_SCAN_RD;
      ST_EMIT:         if (!out_stall && sts.emit_last) state_next = ST_IDLE;
      default:         state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall  = state != ST_IDLE;
    out_valid = state == ST_EMIT;
    unique case (state)
      ST_IDLE: begin
        cmd.load  = in_valid;
        cmd.clear = in_valid && mode_t'(mode) == MODE_CLEAR;
      end
      ST_ADD_A:        cmd.add_a = sts.add_ok;
      ST_ADD_B:        cmd.add_b = 1'b1;
      ST_INIT:         cmd.init = sts.run_ok;
      ST_POP:          cmd.pop = 1'b1;
      ST_SIFT_DOWN:    cmd.sd_step = 1'b1;
      ST_SCAN_RD:      cmd.scan_rd = !sts.pop_skip && sts.scan_more;
      ST_SCAN_WAIT:    cmd.wt_rd = 1'b1;
      ST_SCAN:         cmd.scan = 1'b1;
      ST_FIND:         cmd.find_step = !sts.find_end;
      ST_SIFT_UP:      cmd.su_step = 1'b1;
      ST_EMIT:         cmd.emit_next = !out_stall;
      default:         cmd = '0;
    endcase
  end

  a_emit_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT) else $error("output beat outside report");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("accept while busy");
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("report dropped");
endmodule
`default_nettype wire

FILE: design/prim_mst_binary_heap_top.sv
// Prim spanning tree with binary-heap queue; top level joining ctrl and datapath.
// Edge load: to both lists unless an endpoint is out of range. Clear, unused mode: in idle.
// Run: accept, init; per extracted vertex a pop, then sift-down swaps until settled;
// per listed neighbour read, weight read, scan, then a sift-up or heap search and sift-up.
// Then one report beat per vertex in use; one item in flight, next beat taken after the last.
// Synchronous reset empties lists, sets 32 vertices; no clearing pass.
`default_nettype none
module prim_mst_binary_heap_top
  import pmbh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CntBits-1:0]    cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            mode,
  input  wire logic [VtxBits-1:0]    vertex_a,
  input  wire logic [VtxBits-1:0]    vertex_b,
  input  wire logic [WeightBits-1:0] weight,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VtxBits-1:0]         vertex,
  output logic [VtxBits-1:0]         parent,
  output logic                       has_parent,
  output logic                       last
);
  cmd_t cmd;
  sts_t sts;

  pmbh_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .mode, .out_valid, .out_stall, .sts, .cmd
  );

  pmbh_datapath u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we, .cfg_wdata, .vertex_a, .vertex_b,
    .weight, .vertex, .parent, .has_parent, .last
  );
endmodule
`default_nettype wire
